@@ sv/utf8d_pkg.sv @@
// shared types, constants and helpers for the utf-8 code point decoder
package utf8d_pkg;

  localparam int unsigned CpWidth    = 21;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned KindWidth  = 3;
  localparam int unsigned ByteWidth  = 8;
  // code point and lead count packed into whole bytes
  localparam int unsigned OutDataWidth = ((CpWidth + CountWidth + 7) / 8) * 8;

  localparam logic [7:0] MaskLead2  = 8'h1F;
  localparam logic [7:0] MaskLead3  = 8'h0F;
  localparam logic [7:0] MaskLead4  = 8'h07;
  localparam logic [7:0] MaskCont   = 8'h3F;
  localparam logic [1:0] SkipAfterBad = 2'd3;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  localparam logic [KindWidth-1:0] KIND_VALID   = 3'd0;
  localparam logic [KindWidth-1:0] KIND_STRAY   = 3'd1;
  localparam logic [KindWidth-1:0] KIND_BADLEAD = 3'd2;
  localparam logic [KindWidth-1:0] KIND_TRUNC   = 3'd3;
  localparam logic [KindWidth-1:0] KIND_END     = 3'd4;

  typedef struct packed {
    logic [CpWidth-1:0]    code_point;
    logic [KindWidth-1:0]  kind;
    logic                  stream_done;
    logic [CountWidth-1:0] lead_total;
  } result_t;

  // leading ones of a byte, five or more reported as five
  function automatic logic [2:0] lead_ones(input logic [7:0] b);
    logic [2:0] n;
    casez (b)
      8'b0???????: n = 3'd0;
      8'b10??????: n = 3'd1;
      8'b110?????: n = 3'd2;
      8'b1110????: n = 3'd3;
      8'b11110???: n = 3'd4;
      default:     n = 3'd5;
    endcase
    return n;
  endfunction

endpackage

@@ sv/utf8_code_point_decoder.sv @@
// utf-8 byte stream to code point decoder, top level
//
// Input channel s_axis: one byte per beat in tdata, tlast marks the last
// byte of a stream. Output channel m_axis: one result per beat; tdata holds
// the code point and the saturating lead-byte count, tuser the result kind,
// tlast flags the result made by the last stream byte.
// A byte is decoded in the cycle it is accepted and its result, if any,
// is registered (in the skid entry while the output stalls). Throughput
// is one byte per cycle while s_axis_tready is high; a byte that only starts
// or continues a multi-byte sequence, or is skipped, gives no output beat.
// The output register has a one-entry skid buffer, so s_axis_tready stays
// high while a finished result waits; it drops only once both the output
// register and the skid entry are full, and returns once m_axis_tready
// takes a beat.
// Synchronous reset clears the decode state, the lead count and both
// output entries. After a beat with tlast all decode state returns to the
// reset values, so the next byte starts a new stream.
`default_nettype none

module utf8_code_point_decoder
  import utf8d_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [ByteWidth-1:0]    s_axis_tdata,   // [7:0] byte_in
  input  wire logic                    s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [OutDataWidth-1:0]      m_axis_tdata,   // [20:0] code_point, [52:21] lead_total
  output logic [KindWidth-1:0]         m_axis_tuser,   // [2:0] kind
  output logic                         m_axis_tlast
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  utf8d_step u_step (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .byte_in   (s_axis_tdata),
    .end_flag  (s_axis_tlast),
    .res_valid (res_valid),
    .res       (res)
  );

  utf8d_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept && res_valid),
    .in_ready  (s_axis_tready),
    .in_data   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = OutDataWidth'({out_res.lead_total, out_res.code_point});
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.stream_done;

endmodule

`default_nettype wire

@@ sv/utf8d_step.sv @@
// decode state and per-byte result logic
`default_nettype none

module utf8d_step
  import utf8d_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic [ByteWidth-1:0] byte_in,
  input  wire logic                 end_flag,
  output logic                      res_valid,
  output result_t                   res
);

  logic [CpWidth-1:0]    partial_value;
  logic [CpWidth-1:0]    partial_value_next;
  logic [1:0]            bytes_expected;
  logic [1:0]            bytes_expected_next;
  logic [1:0]            bytes_to_skip;
  logic [1:0]            bytes_to_skip_next;
  logic [CountWidth-1:0] lead_counter;
  logic [CountWidth-1:0] lead_counter_next;
  logic [CountWidth-1:0] lead_count_now;
  logic [2:0]            ones;
  logic [CpWidth-1:0]    shifted;

  assign ones    = lead_ones(byte_in);
  assign shifted = {partial_value[CpWidth-7:0], byte_in[5:0] & MaskCont[5:0]};

  always_comb begin
    lead_count_now = lead_counter;
    if (ones != 3'd1 && ones <= 3'd4 && lead_counter != CountMax) begin
      lead_count_now = lead_counter + 1'b1;
    end

    partial_value_next  = partial_value;
    bytes_expected_next = bytes_expected;
    bytes_to_skip_next  = bytes_to_skip;
    res_valid           = 1'b0;
    res.code_point      = '0;
    res.kind            = KIND_VALID;
    res.stream_done     = end_flag;
    res.lead_total      = lead_count_now;

    if (bytes_to_skip != 2'd0) begin
      bytes_to_skip_next = bytes_to_skip - 2'd1;
      if (end_flag) begin
        res_valid = 1'b1;
        res.kind  = KIND_END;
      end
    end else if (bytes_expected != 2'd0) begin
      partial_value_next  = shifted;
      bytes_expected_next = bytes_expected - 2'd1;
      res.code_point      = shifted;
      if (bytes_expected == 2'd1) begin
        res_valid          = 1'b1;
        partial_value_next = '0;
      end else if (end_flag) begin
        res_valid = 1'b1;
        res.kind  = KIND_TRUNC;
      end
    end else begin
      case (ones)
        3'd0: begin
          res_valid      = 1'b1;
          res.code_point = CpWidth'(byte_in);
        end
        3'd1: begin
          res_valid      = 1'b1;
          res.kind       = KIND_STRAY;
          res.code_point = CpWidth'(byte_in);
        end
        3'd2, 3'd3, 3'd4: begin
          if (ones == 3'd2) begin
            partial_value_next = CpWidth'(byte_in & MaskLead2);
          end else if (ones == 3'd3) begin
            partial_value_next = CpWidth'(byte_in & MaskLead3);
          end else begin
            partial_value_next = CpWidth'(byte_in & MaskLead4);
          end
          bytes_expected_next = ones[1:0] - 2'd1;
          res.code_point      = partial_value_next;
          res.kind            = KIND_TRUNC;
          res_valid           = end_flag;
        end
        default: begin
          res_valid          = 1'b1;
          res.kind           = KIND_BADLEAD;
          res.code_point     = CpWidth'(byte_in);
          bytes_to_skip_next = SkipAfterBad;
        end
      endcase
    end

    lead_counter_next = lead_count_now;
    // last beat of a stream returns everything to the reset state
    if (end_flag) begin
      partial_value_next  = '0;
      bytes_expected_next = 2'd0;
      bytes_to_skip_next  = 2'd0;
      lead_counter_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value  <= '0;
      bytes_expected <= 2'd0;
      bytes_to_skip  <= 2'd0;
      lead_counter   <= '0;
    end else if (accept) begin
      partial_value  <= partial_value_next;
      bytes_expected <= bytes_expected_next;
      bytes_to_skip  <= bytes_to_skip_next;
      lead_counter   <= lead_counter_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/utf8d_out_stage.sv @@
// result register with a skid entry so the input side keeps flowing
`default_nettype none

module utf8d_out_stage
  import utf8d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  result_t   in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   out_data
);

  logic    skid_valid;
  result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && !skid_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

@@ sv/utf8d_checker.sv @@
// port-level checks for the utf-8 decoder, bound to the top level
`default_nettype none

module utf8d_checker
  import utf8d_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    m_axis_tvalid,
  input wire logic                    m_axis_tready,
  input wire logic [OutDataWidth-1:0] m_axis_tdata,
  input wire logic [KindWidth-1:0]    m_axis_tuser,
  input wire logic                    m_axis_tlast
);

  // a stalled beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled output beat changed");

  // no output beat right after reset
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  // end-only result carries zero and closes the stream
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_END |->
      m_axis_tlast && m_axis_tdata[CpWidth-1:0] == '0)
    else $error("end-only result malformed");

  // stray continuation is the raw 10xxxxxx byte
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_STRAY |->
      m_axis_tdata[CpWidth-1:8] == '0 && m_axis_tdata[7:6] == 2'b10)
    else $error("stray continuation value malformed");

endmodule

bind utf8_code_point_decoder utf8d_checker u_utf8d_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
